// ===== src/sle_pkg.sv =====
// ----------------------------------------------------------------------------
// sle_pkg
// Types and constants shared by the sequential list engine.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY      = 64;
  localparam int ELEMENT_WIDTH = 32;
  localparam int AW            = $clog2(CAPACITY);
  localparam int CW            = $clog2(CAPACITY + 1);

  typedef logic [AW-1:0]            addr_t;
  typedef logic [CW-1:0]            count_t;
  typedef logic [ELEMENT_WIDTH-1:0] elem_t;

  typedef enum logic [3:0] {
    CMD_CLEAR    = 4'd0,
    CMD_INSERT   = 4'd1,
    CMD_DELETE   = 4'd2,
    CMD_LOCATE   = 4'd3,
    CMD_DELMIN   = 4'd4,
    CMD_REVERSE  = 4'd5,
    CMD_DELVALUE = 4'd6,
    CMD_DELRANGE = 4'd7,
    CMD_DEDUP    = 4'd8,
    CMD_DUMP     = 4'd9
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_POS = 3'd1,
    ST_FULL    = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_BAD_RNG = 3'd4
  } status_t;

endpackage

// ===== src/sequential_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// sequential_list_engine_core
// Ordered list of signed words in a synchronous store with one write and one read port.
// ----------------------------------------------------------------------------
// Clear, unused codes and error codes go straight to the result state; shifting,
//   compacting, reversing or scanning commands step through the entries (read,
//   settle, write per entry).
// Dump strobes one result per element.
// Throughput: one request at a time; busy is high until the last result.
// Reset: count and control clear; store contents undefined until written.
module sequential_list_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_command,
  input  logic [6:0]  in_position,
  input  logic signed [31:0] in_value,
  input  logic signed [31:0] in_upper_bound,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic signed [31:0] out_element,
  output logic [6:0]  out_found_position,
  output logic [6:0]  out_list_length,
  output logic        out_last
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RD    = 6'b000010,
    S_EVAL  = 6'b000100,
    S_WR    = 6'b001000,
    S_WR2   = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t            state_r;
  sle_pkg::cmd_t     cmd_r;
  logic [6:0]        pos_r;
  sle_pkg::elem_t    v_r, ub_r;
  sle_pkg::count_t   cnt_r;
  sle_pkg::count_t   i_r, k_r, j_r;
  sle_pkg::elem_t    hold_r, min_r, prev_r;
  sle_pkg::count_t   mi_r;
  logic [2:0]        st_r;
  sle_pkg::elem_t    el_r;
  logic [6:0]        fp_r;
  logic              phase_r;

  sle_pkg::elem_t    mem [sle_pkg::CAPACITY];
  logic              we;
  sle_pkg::addr_t    waddr, raddr;
  sle_pkg::elem_t    wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  logic signed [sle_pkg::ELEMENT_WIDTH-1:0] rs, vs, ubs, ms;
  assign rs  = rdata_r;
  assign vs  = v_r;
  assign ubs = ub_r;
  assign ms  = min_r;

  logic in_rng;
  assign in_rng = (rs >= vs) && (rs <= ubs);

  assign busy = (state_r != S_IDLE);

  // Read address and write port are decided combinationally from state.
  always_comb begin
    we    = 1'b0;
    waddr = i_r[sle_pkg::AW-1:0];
    wdata = rdata_r;
    raddr = i_r[sle_pkg::AW-1:0];
    case (state_r)
      S_WR: begin
        we = 1'b1;
        case (cmd_r)
          sle_pkg::CMD_INSERT: begin
            waddr = i_r[sle_pkg::AW-1:0];
            wdata = (i_r == sle_pkg::count_t'(pos_r - 7'd1)) ? v_r : rdata_r;
          end
          sle_pkg::CMD_DELETE, sle_pkg::CMD_DELVALUE, sle_pkg::CMD_DELRANGE,
          sle_pkg::CMD_DEDUP: begin
            waddr = k_r[sle_pkg::AW-1:0];
            wdata = rdata_r;
          end
          sle_pkg::CMD_DELMIN: begin
            waddr = mi_r[sle_pkg::AW-1:0];
            wdata = rdata_r;
          end
          sle_pkg::CMD_REVERSE: begin
            waddr = i_r[sle_pkg::AW-1:0];
            wdata = rdata_r;
          end
          default: we = 1'b0;
        endcase
      end
      S_WR2: begin
        we    = 1'b1;
        waddr = j_r[sle_pkg::AW-1:0];
        wdata = hold_r;
      end
      S_RD, S_EVAL: begin
        case (cmd_r)
          sle_pkg::CMD_INSERT:  raddr = sle_pkg::AW'(i_r - 1'b1);
          sle_pkg::CMD_REVERSE: raddr = phase_r ? j_r[sle_pkg::AW-1:0]
                                                : i_r[sle_pkg::AW-1:0];
          sle_pkg::CMD_DELMIN:  raddr = phase_r ? sle_pkg::AW'(cnt_r - 1'b1)
                                                : i_r[sle_pkg::AW-1:0];
          default:              raddr = i_r[sle_pkg::AW-1:0];
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r   <= sle_pkg::cmd_t'(in_command);
            pos_r   <= in_position;
            v_r     <= in_value[sle_pkg::ELEMENT_WIDTH-1:0];
            ub_r    <= in_upper_bound[sle_pkg::ELEMENT_WIDTH-1:0];
            st_r    <= sle_pkg::ST_OK;
            el_r    <= '0;
            fp_r    <= '0;
            phase_r <= 1'b0;
            k_r     <= '0;
            mi_r    <= '0;
            state_r <= S_DONE;
            case (in_command)
              sle_pkg::CMD_CLEAR: cnt_r <= '0;
              sle_pkg::CMD_INSERT: begin
                if (in_position == 7'd0 || {1'b0, in_position} > 8'(cnt_r) + 8'd1)
                  st_r <= sle_pkg::ST_BAD_POS;
                else if (cnt_r == sle_pkg::count_t'(sle_pkg::CAPACITY))
                  st_r <= sle_pkg::ST_FULL;
                else begin
                  i_r <= cnt_r;
                  state_r <= (sle_pkg::count_t'(in_position - 7'd1) == cnt_r)
                             ? S_WR : S_RD;
                end
              end
              sle_pkg::CMD_DELETE: begin
                if (in_position == 7'd0 || sle_pkg::count_t'(in_position) > cnt_r)
                  st_r <= sle_pkg::ST_BAD_POS;
                else begin
                  i_r <= sle_pkg::count_t'(in_position - 7'd1);
                  k_r <= sle_pkg::count_t'(in_position - 7'd1);
                  state_r <= S_RD;
                end
              end
              sle_pkg::CMD_LOCATE, sle_pkg::CMD_DELVALUE: begin
                i_r <= '0;
                state_r <= (cnt_r == '0) ? S_DONE : S_RD;
              end
              sle_pkg::CMD_DELMIN, sle_pkg::CMD_DEDUP: begin
                if (cnt_r == '0) st_r <= sle_pkg::ST_EMPTY;
                else begin
                  i_r <= '0;
                  state_r <= S_RD;
                end
              end
              sle_pkg::CMD_REVERSE: begin
                i_r <= '0;
                j_r <= cnt_r - 1'b1;
                state_r <= (cnt_r < sle_pkg::count_t'(2)) ? S_DONE : S_RD;
              end
              sle_pkg::CMD_DELRANGE: begin
                if ($signed(in_value[sle_pkg::ELEMENT_WIDTH-1:0]) >=
                    $signed(in_upper_bound[sle_pkg::ELEMENT_WIDTH-1:0]))
                  st_r <= sle_pkg::ST_BAD_RNG;
                else if (cnt_r == '0) st_r <= sle_pkg::ST_EMPTY;
                else begin
                  i_r <= '0;
                  state_r <= S_RD;
                end
              end
              sle_pkg::CMD_DUMP: begin
                if (cnt_r == '0) st_r <= sle_pkg::ST_EMPTY;
                else begin
                  i_r <= '0;
                  state_r <= S_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_RD: state_r <= S_EVAL;
        S_EVAL: begin
          case (cmd_r)
            sle_pkg::CMD_INSERT: state_r <= S_WR;
            sle_pkg::CMD_DELETE: begin
              if (i_r == k_r && phase_r == 1'b0) begin
                el_r    <= rdata_r;
                phase_r <= 1'b1;
                i_r     <= i_r + 1'b1;
                if (i_r + 1'b1 >= cnt_r) begin
                  cnt_r <= cnt_r - 1'b1;
                  state_r <= S_DONE;
                end else state_r <= S_RD;
              end else state_r <= S_WR;
            end
            sle_pkg::CMD_LOCATE: begin
              if (rdata_r == v_r) begin
                fp_r <= 7'(i_r + 1'b1);
                state_r <= S_DONE;
              end else if (i_r + 1'b1 >= cnt_r) state_r <= S_DONE;
              else begin
                i_r <= i_r + 1'b1;
                state_r <= S_RD;
              end
            end
            sle_pkg::CMD_DELMIN: begin
              if (phase_r) state_r <= S_WR;
              else begin
                if (i_r == '0 || rs < ms) begin
                  min_r <= rdata_r;
                  mi_r  <= i_r;
                end
                if (i_r + 1'b1 >= cnt_r) begin
                  phase_r <= 1'b1;
                  state_r <= S_RD;
                end else begin
                  i_r <= i_r + 1'b1;
                  state_r <= S_RD;
                end
              end
            end
            sle_pkg::CMD_REVERSE: begin
              if (!phase_r) begin
                hold_r  <= rdata_r;
                phase_r <= 1'b1;
                state_r <= S_RD;
              end else state_r <= S_WR;
            end
            sle_pkg::CMD_DELVALUE, sle_pkg::CMD_DELRANGE: begin
              if ((cmd_r == sle_pkg::CMD_DELVALUE) ? (rdata_r != v_r) : !in_rng)
                state_r <= S_WR;
              else if (i_r + 1'b1 >= cnt_r) begin
                cnt_r <= k_r;
                state_r <= S_DONE;
              end else begin
                i_r <= i_r + 1'b1;
                state_r <= S_RD;
              end
            end
            sle_pkg::CMD_DEDUP: begin
              if (i_r == '0) begin
                prev_r <= rdata_r;
                if (cnt_r == sle_pkg::count_t'(1)) begin
                  cnt_r <= sle_pkg::count_t'(1);
                  state_r <= S_DONE;
                end else begin
                  i_r <= i_r + 1'b1;
                  state_r <= S_RD;
                end
              end else if (rdata_r != prev_r) begin
                k_r <= k_r + 1'b1;
                prev_r <= rdata_r;
                state_r <= S_WR;
              end else if (i_r + 1'b1 >= cnt_r) begin
                cnt_r <= k_r + 1'b1;
                state_r <= S_DONE;
              end else begin
                i_r <= i_r + 1'b1;
                state_r <= S_RD;
              end
            end
            sle_pkg::CMD_DUMP: begin
              out_valid          <= 1'b1;
              out_status         <= sle_pkg::ST_OK;
              out_element        <= 32'(rs);
              out_found_position <= '0;
              out_list_length    <= 7'(cnt_r);
              out_last           <= (i_r + 1'b1 >= cnt_r);
              if (i_r + 1'b1 >= cnt_r) state_r <= S_IDLE;
              else begin
                i_r <= i_r + 1'b1;
                state_r <= S_RD;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_WR: begin
          case (cmd_r)
            sle_pkg::CMD_INSERT: begin
              if (i_r == sle_pkg::count_t'(pos_r - 7'd1)) begin
                cnt_r <= cnt_r + 1'b1;
                state_r <= S_DONE;
              end else begin
                i_r <= i_r - 1'b1;
                state_r <= (i_r - 1'b1 == sle_pkg::count_t'(pos_r - 7'd1))
                           ? S_WR : S_RD;
              end
            end
            sle_pkg::CMD_DELETE: begin
              k_r <= k_r + 1'b1;
              if (i_r + 1'b1 >= cnt_r) begin
                cnt_r <= cnt_r - 1'b1;
                state_r <= S_DONE;
              end else begin
                i_r <= i_r + 1'b1;
                state_r <= S_RD;
              end
            end
            sle_pkg::CMD_DELMIN: begin
              el_r  <= min_r;
              cnt_r <= cnt_r - 1'b1;
              state_r <= S_DONE;
            end
            sle_pkg::CMD_REVERSE: state_r <= S_WR2;
            sle_pkg::CMD_DELVALUE, sle_pkg::CMD_DELRANGE: begin
              if (i_r + 1'b1 >= cnt_r) begin
                cnt_r <= k_r + 1'b1;
                state_r <= S_DONE;
              end else begin
                k_r <= k_r + 1'b1;
                i_r <= i_r + 1'b1;
                state_r <= S_RD;
              end
            end
            sle_pkg::CMD_DEDUP: begin
              if (i_r + 1'b1 >= cnt_r) begin
                cnt_r <= k_r + 1'b1;
                state_r <= S_DONE;
              end else begin
                i_r <= i_r + 1'b1;
                state_r <= S_RD;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_WR2: begin
          phase_r <= 1'b0;
          if (i_r + 1'b1 >= j_r - 1'b1 || i_r + 1'b1 == j_r) state_r <= S_DONE;
          else begin
            i_r <= i_r + 1'b1;
            j_r <= j_r - 1'b1;
            state_r <= S_RD;
          end
        end
        S_DONE: begin
          out_valid          <= 1'b1;
          out_status         <= st_r;
          out_element        <= 32'($signed(el_r));
          out_found_position <= fp_r;
          out_list_length    <= 7'(cnt_r);
          out_last           <= 1'b1;
          state_r            <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/sle_checker.sv =====
// ----------------------------------------------------------------------------
// sle_checker
// Port-level checks on the sequential list engine.
// ----------------------------------------------------------------------------
module sle_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [2:0] out_status,
  input logic [6:0] out_list_length,
  input logic       out_last
);

  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_list_length <= 7'd64) else $error("length above capacity");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("request not taken");

  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'd4) else $error("bad status");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy) else $error("busy after last");

endmodule

bind sequential_list_engine_core sle_checker u_sle_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_status(out_status),
  .out_list_length(out_list_length), .out_last(out_last)
);

// ===== test/sequential_list_engine_core_tb.sv =====
// ----------------------------------------------------------------------------
// sequential_list_engine_core_tb
// Drives list commands in random bursts, predicts every result from a local
// copy of the list and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module sequential_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [3:0]         command;
    logic [6:0]         position;
    logic signed [31:0] value;
    logic signed [31:0] upper_bound;
  } request_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] element;
    logic [6:0]         found_position;
    logic [6:0]         list_length;
    logic               last;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [3:0] in_command = '0;
  logic [6:0] in_position = '0;
  logic signed [31:0] in_value = '0;
  logic signed [31:0] in_upper_bound = '0;
  logic out_valid;
  logic [2:0] out_status;
  logic signed [31:0] out_element;
  logic [6:0] out_found_position;
  logic [6:0] out_list_length;
  logic out_last;

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  logic signed [31:0] model_list[$];
  int gen_count = 0;
  int errors = 0;
  bit hold_sender = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  sequential_list_engine_core dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic reply_t mk_reply(logic [2:0] st, logic signed [31:0] el,
                                      logic [6:0] fp, logic lst);
    reply_t r;
    r.status = st;
    r.element = el;
    r.found_position = fp;
    r.list_length = 7'(model_list.size());
    r.last = lst;
    return r;
  endfunction

  task automatic apply_list_command(request_t q);
    int n;
    int mi;
    logic [2:0] st;
    logic signed [31:0] el;
    logic [6:0] fp;
    logic signed [31:0] kept[$];
    n = model_list.size();
    st = sle_pkg::ST_OK;
    el = '0;
    fp = '0;
    case (q.command)
      sle_pkg::CMD_CLEAR: model_list.delete();
      sle_pkg::CMD_INSERT: begin
        if (q.position < 1 || q.position > n + 1) st = sle_pkg::ST_BAD_POS;
        else if (n >= sle_pkg::CAPACITY) st = sle_pkg::ST_FULL;
        else model_list.insert(q.position - 1, q.value);
      end
      sle_pkg::CMD_DELETE: begin
        if (q.position < 1 || q.position > n) st = sle_pkg::ST_BAD_POS;
        else begin
          el = model_list[q.position - 1];
          model_list.delete(q.position - 1);
        end
      end
      sle_pkg::CMD_LOCATE: begin
        for (int i = 0; i < n; i++)
          if (fp == 0 && model_list[i] == q.value) fp = 7'(i + 1);
      end
      sle_pkg::CMD_DELMIN: begin
        if (n == 0) st = sle_pkg::ST_EMPTY;
        else begin
          mi = 0;
          for (int i = 1; i < n; i++) if (model_list[i] < model_list[mi]) mi = i;
          el = model_list[mi];
          model_list[mi] = model_list[n - 1];
          model_list.delete(n - 1);
        end
      end
      sle_pkg::CMD_REVERSE: model_list.reverse();
      sle_pkg::CMD_DELVALUE: begin
        foreach (model_list[i]) if (model_list[i] != q.value) kept.push_back(model_list[i]);
        model_list = kept;
      end
      sle_pkg::CMD_DELRANGE: begin
        if (q.value >= q.upper_bound) st = sle_pkg::ST_BAD_RNG;
        else if (n == 0) st = sle_pkg::ST_EMPTY;
        else begin
          foreach (model_list[i])
            if (model_list[i] < q.value || model_list[i] > q.upper_bound)
              kept.push_back(model_list[i]);
          model_list = kept;
        end
      end
      sle_pkg::CMD_DEDUP: begin
        if (n == 0) st = sle_pkg::ST_EMPTY;
        else begin
          kept.push_back(model_list[0]);
          for (int i = 1; i < n; i++)
            if (kept[kept.size() - 1] != model_list[i]) kept.push_back(model_list[i]);
          model_list = kept;
        end
      end
      sle_pkg::CMD_DUMP: begin
        if (n == 0) st = sle_pkg::ST_EMPTY;
        else begin
          for (int i = 0; i < n; i++)
            expected_replies.push_back(mk_reply(sle_pkg::ST_OK, model_list[i], '0,
                                                i == n - 1));
          return;
        end
      end
      default: ;
    endcase
    expected_replies.push_back(mk_reply(st, el, fp, 1'b1));
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $urandom();
      default: return $signed($urandom_range(0, 12)) - 6;
    endcase
  endfunction

  function automatic request_t make_request(logic [3:0] c, logic [6:0] p,
                                            logic signed [31:0] v,
                                            logic signed [31:0] u);
    request_t q;
    q.command = c;
    q.position = p;
    q.value = v;
    q.upper_bound = u;
    return q;
  endfunction

  function automatic request_t rand_request();
    logic [3:0] c;
    logic signed [31:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) c = sle_pkg::CMD_INSERT;
    else if (r < 48) c = sle_pkg::CMD_DELETE;
    else if (r < 56) c = sle_pkg::CMD_LOCATE;
    else if (r < 62) c = sle_pkg::CMD_DELMIN;
    else if (r < 66) c = sle_pkg::CMD_REVERSE;
    else if (r < 72) c = sle_pkg::CMD_DELVALUE;
    else if (r < 78) c = sle_pkg::CMD_DELRANGE;
    else if (r < 84) c = sle_pkg::CMD_DEDUP;
    else if (r < 92) c = sle_pkg::CMD_DUMP;
    else if (r < 94) c = sle_pkg::CMD_CLEAR;
    else c = 4'($urandom_range(10, 15));
    v = rand_value();
    return make_request(c, 7'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                              : $urandom_range(0, 66)), v,
                        ($urandom_range(0, 3) == 0) ? rand_value() : v + $urandom_range(0, 8));
  endfunction

  initial begin
    pending_requests.push_back(make_request(sle_pkg::CMD_DELETE, 7'd1, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DELMIN, 7'd0, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DEDUP, 7'd0, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DUMP, 7'd0, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DELRANGE, 7'd0, 1, 5));
    pending_requests.push_back(make_request(sle_pkg::CMD_DELRANGE, 7'd0, 5, 5));
    pending_requests.push_back(make_request(sle_pkg::CMD_INSERT, 7'd0, 3, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_INSERT, 7'd2, 3, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_INSERT, 7'd1, 32'sh7fff_ffff, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_INSERT, 7'd2, 32'sh8000_0000, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_INSERT, 7'd3, 32'sh8000_0000, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_INSERT, 7'd4, -1, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_LOCATE, 7'd0, 32'sh8000_0000, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_LOCATE, 7'd0, 9, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DUMP, 7'd0, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DEDUP, 7'd0, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_REVERSE, 7'd0, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DELMIN, 7'd0, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DELETE, 7'd3, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DELETE, 7'd127, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DELVALUE, 7'd0, -1, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DELRANGE, 7'd0, 32'sh8000_0000,
                                            32'sh7fff_ffff));
    pending_requests.push_back(make_request(4'd15, 7'h7f, -1, -1));
    for (int i = 0; i < 66; i++)
      pending_requests.push_back(make_request(sle_pkg::CMD_INSERT, 7'($urandom_range(1, 3)),
                                              $urandom(), 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DUMP, 7'd0, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_DEDUP, 7'd0, 0, 0));
    pending_requests.push_back(make_request(sle_pkg::CMD_CLEAR, 7'd0, 0, 0));
    for (int i = 0; i < 180; i++) pending_requests.push_back(rand_request());
    gen_count = pending_requests.size();
  end

  // sender: bursts and gaps, one pause until drained midway
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start) begin
        apply_list_command(make_request(in_command, in_position, in_value, in_upper_bound));
        if (pending_requests.size() == gen_count / 2) hold_sender <= 1'b1;
      end
      if (hold_sender && expected_replies.size() == 0 && !start) hold_sender <= 1'b0;
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_requests.size() > 0 && !(hold_sender || (start &&
                   pending_requests.size() == gen_count / 2))) begin
        request_t q;
        q = pending_requests.pop_front();
        in_command <= q.command;
        in_position <= q.position;
        in_value <= q.value;
        in_upper_bound <= q.upper_bound;
        start <= 1'b1;
        if (burst_left > 0) burst_left <= burst_left - 1;
        else begin
          burst_left <= $urandom_range(0, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid) begin
      if (expected_replies.size() == 0) begin
        $error("unexpected result: status %0d element %0d", out_status, out_element);
        errors++;
      end else begin
        want = expected_replies.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_status); errors++;
        end
        if (out_element !== want.element) begin
          $error("element: expected %0d actual %0d", want.element, out_element); errors++;
        end
        if (out_found_position !== want.found_position) begin
          $error("found_position: expected %0d actual %0d", want.found_position,
                 out_found_position); errors++;
        end
        if (out_list_length !== want.list_length) begin
          $error("list_length: expected %0d actual %0d", want.list_length,
                 out_list_length); errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, out_last); errors++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_requests.size() > 0 || start || busy || expected_replies.size() > 0)
      @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("PASS sequential_list_engine_core");
    end else begin
      $display("FAIL sequential_list_engine_core");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("FAIL sequential_list_engine_core");
    $finish;
  end
endmodule

// ===== sim.f =====
src/sle_pkg.sv
src/sequential_list_engine_core.sv
src/sle_checker.sv
test/sequential_list_engine_core_tb.sv
